FILE: rtl/kdhr_pkg.sv
// ----------------------------------------------------------------------------
// kdhr_pkg
// Types and constants shared by the key debounce / hold / repeat block.
// ----------------------------------------------------------------------------
package kdhr_pkg;

	localparam int unsigned THR_W   = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic LEVEL_LOW  = 1'b0;
	localparam logic LEVEL_HIGH = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 1'b1;

	localparam logic [THR_W-1:0] FIRST_HOLD_RST = 16'd100;
	localparam logic [THR_W-1:0] REPEAT_RST     = 16'd20;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_CONFIRM = 2'd1,
		ST_HELD    = 2'd2,
		ST_WAIT    = 2'd3
	} state_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_HOLD    = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_RELEASE = 3'd4
	} event_t;

	typedef struct packed {
		logic   raw_level;
		event_t key_event;
	} result_t;

endpackage

FILE: rtl/kdhr_fsm.sv
// ----------------------------------------------------------------------------
// kdhr_fsm
// Debounce state machine, hold counter and repeat flag; one step per sample.
// ----------------------------------------------------------------------------
module kdhr_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          level,
	input  logic [kdhr_pkg::THR_W-1:0]    first_hold_ticks,
	input  logic [kdhr_pkg::THR_W-1:0]    repeat_ticks,
	output kdhr_pkg::result_t             res
);

	kdhr_pkg::state_t state_q, state_d;
	logic [kdhr_pkg::COUNT_W-1:0] count_q, count_d, count_inc;
	logic armed_q, armed_d;
	logic rep_hit, hold_hit;

	assign count_inc = count_q + 1'b1;
	assign rep_hit   = armed_q && (count_inc > {1'b0, repeat_ticks});
	assign hold_hit  = count_inc > {1'b0, first_hold_ticks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kdhr_pkg::ST_IDLE;
			count_q <= '0;
			armed_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			count_q <= count_d;
			armed_q <= armed_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		armed_d = armed_q;
		unique case (state_q)
			kdhr_pkg::ST_IDLE: begin
				if (level != kdhr_pkg::LEVEL_LOW) state_d = kdhr_pkg::ST_CONFIRM;
			end
			kdhr_pkg::ST_CONFIRM: begin
				state_d = (level != kdhr_pkg::LEVEL_LOW) ? kdhr_pkg::ST_HELD
				                                        : kdhr_pkg::ST_IDLE;
			end
			kdhr_pkg::ST_HELD: begin
				if (level != kdhr_pkg::LEVEL_LOW) begin
					count_d = count_inc;
					if (rep_hit) begin
						count_d = '0;
					end else if (hold_hit) begin
						count_d = '0;
						armed_d = 1'b1;
					end
				end else begin
					state_d = kdhr_pkg::ST_IDLE;
					count_d = '0;
					armed_d = 1'b0;
				end
			end
			default: begin
				// unreachable wait code: release on low, otherwise stay
				if (level == kdhr_pkg::LEVEL_LOW) begin
					state_d = kdhr_pkg::ST_IDLE;
					count_d = '0;
					armed_d = 1'b0;
				end
			end
		endcase
	end

	// event output
	always_comb begin
		res.raw_level = level;
		res.key_event = kdhr_pkg::EV_NONE;
		unique case (state_q)
			kdhr_pkg::ST_IDLE: res.key_event = kdhr_pkg::EV_NONE;
			kdhr_pkg::ST_CONFIRM: begin
				if (level != kdhr_pkg::LEVEL_LOW) res.key_event = kdhr_pkg::EV_PRESS;
			end
			kdhr_pkg::ST_HELD: begin
				if (level == kdhr_pkg::LEVEL_LOW) res.key_event = kdhr_pkg::EV_RELEASE;
				else if (rep_hit)                 res.key_event = kdhr_pkg::EV_REPEAT;
				else if (hold_hit)                res.key_event = kdhr_pkg::EV_HOLD;
			end
			default: begin
				if (level == kdhr_pkg::LEVEL_LOW) res.key_event = kdhr_pkg::EV_RELEASE;
			end
		endcase
	end

endmodule

FILE: rtl/kdhr_out.sv
// ----------------------------------------------------------------------------
// kdhr_out
// Result register for the master stream side.
// ----------------------------------------------------------------------------
module kdhr_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kdhr_pkg::result_t res,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata
);

	logic              valid_q;
	kdhr_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0000, res_q.raw_level, res_q.key_event};

endmodule

FILE: rtl/key_debounce_hold_repeat.sv
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat
// Debounced key with press, long-hold, autorepeat and release events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one sampled key level per transaction (s_tdata[0]).
//   Master stream: one result per input transaction carrying the event code
//   (none, press, long hold, repeat, release) and the raw level.
//   Config port: cfg_we/cfg_index/cfg_data writes first_hold_ticks (index 0)
//   or repeat_ticks (index 1); write only while the block is idle.
// Result path: each input transaction is captured in the input register, then
//   the state update writes the result register; the result transaction
//   follows once m_tready is high.
// Throughput: 1 transaction per cycle while m_tready is high; the state
//   update is a single increment and two 17-bit compares.
// Reset: state idle, hold counter and repeat flag clear, thresholds 100/20,
//   both stream registers empty.
// Stall: when m_tready is low the result holds; one more sample is taken into
//   the input register, after which s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] key_event, [3] raw_level, [7:4] zero
	input  logic        cfg_we,
	input  logic [kdhr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdhr_pkg::THR_W-1:0]     cfg_data
);

	logic [kdhr_pkg::THR_W-1:0] first_hold_q, repeat_q;
	logic in_valid_s1, pin_s1;
	logic advance, step;
	kdhr_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hold_q <= kdhr_pkg::FIRST_HOLD_RST;
			repeat_q     <= kdhr_pkg::REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kdhr_pkg::CFG_FIRST_HOLD: first_hold_q <= cfg_data;
				kdhr_pkg::CFG_REPEAT:     repeat_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !m_tvalid || m_tready;
	assign step     = in_valid_s1 && advance;
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1 <= s_tdata[0];
		end
	end

	kdhr_fsm u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.level            (pin_s1),
		.first_hold_ticks (first_hold_q),
		.repeat_ticks     (repeat_q),
		.res              (res)
	);

	kdhr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: dv/tb_key_debounce_hold_repeat.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_debounce_hold_repeat
// Self-checking bench for the debounced key with long-hold and autorepeat.
// A scoreboard class tracks the key state machine and hold counter for every
// accepted sample. Each result transaction is checked against the oldest
// predicted event and raw level. The run starts with a directed sequence
// covering bounce, press, hold, repeat and release, and hold events that
// recur while armed. Random press/release runs and noise follow under
// several threshold settings and three idle patterns.
// ----------------------------------------------------------------------------
module tb_key_debounce_hold_repeat;

	localparam int STALL_LIMIT = 2000;

	class key_event_scoreboard;
		kdhr_pkg::state_t                key_state;
		logic [kdhr_pkg::COUNT_W-1:0]    hold_count;
		bit                              repeat_armed;
		logic [kdhr_pkg::THR_W-1:0]      first_hold;
		logic [kdhr_pkg::THR_W-1:0]      repeat_gap;
		kdhr_pkg::result_t               expected_events[$];
		int                              errors;
		int                              n_samples;
		int                              n_results;
		int                              tally[8];

		function new();
			key_state    = kdhr_pkg::ST_IDLE;
			hold_count   = '0;
			repeat_armed = 1'b0;
			first_hold   = kdhr_pkg::FIRST_HOLD_RST;
			repeat_gap   = kdhr_pkg::REPEAT_RST;
			errors       = 0;
			n_samples    = 0;
			n_results    = 0;
			foreach (tally[i]) tally[i] = 0;
		endfunction

		function void set_thresholds(logic [kdhr_pkg::THR_W-1:0] first_val,
		                             logic [kdhr_pkg::THR_W-1:0] rep_val);
			first_hold = first_val;
			repeat_gap = rep_val;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function void release_key(ref kdhr_pkg::event_t ev);
			key_state    = kdhr_pkg::ST_IDLE;
			hold_count   = '0;
			repeat_armed = 1'b0;
			ev           = kdhr_pkg::EV_RELEASE;
		endfunction

		// advance the key state machine by one sample, queue the expected result
		function void advance_key(logic lvl);
			kdhr_pkg::event_t  ev;
			kdhr_pkg::result_t res;
			ev = kdhr_pkg::EV_NONE;
			n_samples++;
			case (key_state)
				kdhr_pkg::ST_IDLE: begin
					if (lvl != kdhr_pkg::LEVEL_LOW)
						key_state = kdhr_pkg::ST_CONFIRM;
				end
				kdhr_pkg::ST_CONFIRM: begin
					if (lvl != kdhr_pkg::LEVEL_LOW) begin
						key_state = kdhr_pkg::ST_HELD;
						ev = kdhr_pkg::EV_PRESS;
					end else begin
						key_state = kdhr_pkg::ST_IDLE;
					end
				end
				kdhr_pkg::ST_HELD: begin
					if (lvl != kdhr_pkg::LEVEL_LOW) begin
						hold_count = hold_count + 1'b1;
						// repeat test wins when armed; hold test only on its failure
						if (repeat_armed && hold_count > {1'b0, repeat_gap}) begin
							hold_count = '0;
							ev = kdhr_pkg::EV_REPEAT;
						end else if (hold_count > {1'b0, first_hold}) begin
							repeat_armed = 1'b1;
							hold_count = '0;
							ev = kdhr_pkg::EV_HOLD;
						end
					end else begin
						release_key(ev);
					end
				end
				default: begin
					if (lvl == kdhr_pkg::LEVEL_LOW)
						release_key(ev);
				end
			endcase
			res.key_event = ev;
			res.raw_level = lvl;
			expected_events.push_back(res);
		endfunction

		task check_result(logic [7:0] data);
			kdhr_pkg::result_t exp_res;
			if (expected_events.size() == 0) begin
				report($sformatf("result 0x%02h with nothing expected", data));
				return;
			end
			exp_res = expected_events.pop_front();
			n_results++;
			tally[exp_res.key_event]++;
			if (data[2:0] !== exp_res.key_event)
				report($sformatf("result %0d: key_event %0d, expected %0d (%s)", n_results,
					data[2:0], exp_res.key_event, exp_res.key_event.name()));
			if (data[3] !== exp_res.raw_level)
				report($sformatf("result %0d: raw_level %b, expected %b", n_results,
					data[3], exp_res.raw_level));
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;   // [0] pin_level, [7:1] zero
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [7:0]                     m_tdata;        // [2:0] key_event, [3] raw_level, [7:4] zero
	logic                           cfg_we = 1'b0;
	logic [kdhr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [kdhr_pkg::THR_W-1:0]     cfg_data = '0;

	key_event_scoreboard sb = new();
	int snd_idle_pct = 23;
	int rcv_idle_pct = 46;
	int stall_cycles = 0;
	int n_settings = 0;

	key_debounce_hold_repeat i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// transaction monitor on both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.advance_key(s_tdata[0]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("key_debounce_hold_repeat verification failed");
			$finish;
		end
	end

	task automatic send_run(input logic lvl, input int count);
		repeat (count) begin
			while ($urandom_range(99) < snd_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {7'd0, lvl};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
	endtask

	// hold off the sender until every result is back, then let the pipe settle
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_thresholds(input logic [kdhr_pkg::THR_W-1:0] first_val,
	                               input logic [kdhr_pkg::THR_W-1:0] rep_val);
		cfg_we    <= 1'b1;
		cfg_index <= kdhr_pkg::CFG_FIRST_HOLD;
		cfg_data  <= first_val;
		@(posedge clk);
		cfg_index <= kdhr_pkg::CFG_REPEAT;
		cfg_data  <= rep_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_thresholds(first_val, rep_val);
		n_settings++;
	endtask

	function automatic logic [kdhr_pkg::THR_W-1:0] pick_threshold();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 15)
			return '1;
		return kdhr_pkg::THR_W'($urandom_range(1, 12));
	endfunction

	// mostly press/release runs of random length up to a cap of 200 samples,
	// sized to reach hold and repeat at small thresholds, the rest short noise bursts
	task automatic random_items(input int n_items);
		int sent;
		int len;
		int cap;
		sent = 0;
		cap = int'(sb.first_hold) + 3 * int'(sb.repeat_gap) + 6;
		if (cap > 200)
			cap = 200;
		while (sent < n_items) begin
			if ($urandom_range(99) < 75) begin
				len = $urandom_range(1, cap);
				if (len > n_items - sent)
					len = n_items - sent;
				send_run(kdhr_pkg::LEVEL_HIGH, len);
				sent += len;
				if (sent < n_items) begin
					len = $urandom_range(1, 4);
					if (len > n_items - sent)
						len = n_items - sent;
					send_run(kdhr_pkg::LEVEL_LOW, len);
					sent += len;
				end
			end else begin
				len = $urandom_range(1, 6);
				if (len > n_items - sent)
					len = n_items - sent;
				repeat (len) send_run(1'($urandom_range(0, 1)), 1);
				sent += len;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bounce, press, first hold, repeats, release
		load_thresholds(16'd2, 16'd1);
		send_run(kdhr_pkg::LEVEL_LOW, 1);
		send_run(kdhr_pkg::LEVEL_HIGH, 1);
		send_run(kdhr_pkg::LEVEL_LOW, 1);
		send_run(kdhr_pkg::LEVEL_HIGH, 2);
		send_run(kdhr_pkg::LEVEL_HIGH, 3);
		send_run(kdhr_pkg::LEVEL_HIGH, 4);
		send_run(kdhr_pkg::LEVEL_LOW, 2);
		// first hold below repeat: hold events keep firing while armed
		wait_quiet();
		load_thresholds(16'd0, 16'd3);
		send_run(kdhr_pkg::LEVEL_HIGH, 5);
		send_run(kdhr_pkg::LEVEL_LOW, 1);

		for (int p = 0; p < 3; p++) begin
			snd_idle_pct = (p == 0) ? 23 : (p == 1) ? 46 : 0;
			rcv_idle_pct = (p == 0) ? 46 : (p == 1) ? 23 : 0;
			for (int s = 0; s < 3; s++) begin
				wait_quiet();
				if (p == 1 && s == 0)
					load_thresholds('0, '0);
				else if (p == 2 && s == 0)
					load_thresholds(kdhr_pkg::FIRST_HOLD_RST, kdhr_pkg::REPEAT_RST);
				else
					load_thresholds(pick_threshold(), pick_threshold());
				random_items(80);
			end
		end

		wait_quiet();
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("covered %0d key samples over %0d threshold settings, three idle patterns",
			sb.n_samples, n_settings);
		$display("events checked: %0d press, %0d long hold, %0d repeat, %0d release",
			sb.tally[kdhr_pkg::EV_PRESS], sb.tally[kdhr_pkg::EV_HOLD],
			sb.tally[kdhr_pkg::EV_REPEAT], sb.tally[kdhr_pkg::EV_RELEASE]);
		if (sb.errors == 0)
			$display("key_debounce_hold_repeat verification clean");
		else
			$display("key_debounce_hold_repeat verification failed");
		$finish;
	end

endmodule
